/* rtl/cce_pkg.sv */
// shared types, register codes and bit functions for the crc engine
package cce_pkg;

	// register indexes, decoded from paddr[4:2]
	localparam logic [2:0] REG_WIDTH_MODE     = 3'd0;
	localparam logic [2:0] REG_POLYNOMIAL     = 3'd1;
	localparam logic [2:0] REG_INITIAL_VALUE  = 3'd2;
	localparam logic [2:0] REG_FINAL_XOR      = 3'd3;
	localparam logic [2:0] REG_REFLECT_INPUT  = 3'd4;
	localparam logic [2:0] REG_REFLECT_OUTPUT = 3'd5;

	// width modes, code 3 behaves as 32 bits
	localparam logic [1:0] WM_8  = 2'd0;
	localparam logic [1:0] WM_16 = 2'd1;
	localparam logic [1:0] WM_32 = 2'd2;

	// item classes handed from front to back
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_LAST  = 2'd1;
	localparam logic [1:0] OP_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  width_mode;
		logic [31:0] polynomial;
		logic [31:0] initial_value;
		logic [31:0] final_xor;
		logic        reflect_input;
		logic        reflect_output;
	} cfg_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} entry_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

	function automatic logic [31:0] rev32(input logic [31:0] v);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = v[31 - i];
		end
		return r;
	endfunction

	// move a w-bit value to the top of a 32-bit word, dropping bits above w
	function automatic logic [31:0] align(input logic [31:0] v, input logic [1:0] wm);
		logic [31:0] r;
		case (wm)
			WM_8:    r = {v[7:0], 24'd0};
			WM_16:   r = {v[15:0], 16'd0};
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] unalign(input logic [31:0] v, input logic [1:0] wm);
		logic [31:0] r;
		case (wm)
			WM_8:    r = {24'd0, v[31:24]};
			WM_16:   r = {16'd0, v[31:16]};
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] width_mask(input logic [1:0] wm);
		logic [31:0] r;
		case (wm)
			WM_8:    r = 32'h0000_00FF;
			WM_16:   r = 32'h0000_FFFF;
			default: r = 32'hFFFF_FFFF;
		endcase
		return r;
	endfunction

	// one byte through the msb-first divider, register and polynomial top-aligned
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [31:0] poly,
			input logic [7:0] b);
		logic [31:0] x;
		x = crc ^ {b, 24'd0};
		for (int i = 0; i < 8; i++) begin
			if (x[31]) begin
				x = {x[30:0], 1'b0} ^ poly;
			end else begin
				x = {x[30:0], 1'b0};
			end
		end
		return x;
	endfunction

endpackage

/* rtl/cce_queue.sv */
// small register queue between the front and back parts
module cce_queue #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign rdata     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/cce_front.sv */
// input side: takes transactions, reflects the byte when reflect_input is set and classifies the item
module cce_front (
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     data_byte,
	input  logic           last_byte,
	input  logic           empty_message,
	input  logic           reflect_input,
	input  logic           queue_full,
	output logic           push,
	output cce_pkg::entry_t entry
);

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		entry.data = reflect_input ? cce_pkg::rev8(data_byte) : data_byte;
		// an empty item closes the message whatever last_byte says
		if (empty_message) begin
			entry.op = cce_pkg::OP_EMPTY;
		end else if (last_byte) begin
			entry.op = cce_pkg::OP_LAST;
		end else begin
			entry.op = cce_pkg::OP_BYTE;
		end
	end

endmodule

/* rtl/cce_back.sv */
// execution side: crc register update, finalization and result register
module cce_back (
	input  logic            clk,
	input  logic            arst_n,
	input  cce_pkg::cfg_t   cfg,
	input  logic            head_valid,
	input  cce_pkg::entry_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [31:0]     crc_value
);

	logic [31:0] crc_q;
	logic        in_msg_q;
	logic        out_valid_q;
	logic [31:0] crc_value_q;

	logic [31:0] base;
	logic [31:0] poly_al;
	logic [31:0] stepped;
	logic [31:0] fin_src;
	logic [31:0] result;
	logic        is_empty;
	logic        emit;

	always_comb begin
		// crc_q is kept low-aligned so a width change inside a message keeps the low bits
		base    = in_msg_q ? cce_pkg::align(crc_q, cfg.width_mode)
		                   : cce_pkg::align(cfg.initial_value, cfg.width_mode);
		poly_al = cce_pkg::align(cfg.polynomial, cfg.width_mode);
		stepped = cce_pkg::crc_byte(base, poly_al, head.data);
		case (head.op)
			cce_pkg::OP_EMPTY: begin
				is_empty = 1'b1;
				emit     = 1'b1;
			end
			cce_pkg::OP_LAST: begin
				is_empty = 1'b0;
				emit     = 1'b1;
			end
			default: begin
				is_empty = 1'b0;
				emit     = 1'b0;
			end
		endcase
		fin_src = is_empty ? base : stepped;
		// reversing the top-aligned word lands the reflected value in the low bits
		result  = (cfg.reflect_output ? cce_pkg::rev32(fin_src)
		                              : cce_pkg::unalign(fin_src, cfg.width_mode))
		          ^ (cfg.final_xor & cce_pkg::width_mask(cfg.width_mode));
		pop     = head_valid && (!emit || !out_valid_q || !out_stall);
	end

	always_ff @(posedge clk) begin
		if (pop && !is_empty) begin
			crc_q <= cce_pkg::unalign(stepped, cfg.width_mode);
		end
		if (pop && emit) begin
			crc_value_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				in_msg_q <= !emit;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_value_q;

endmodule

/* rtl/configurable_crc_engine_unit.sv */
// top level of the configurable crc engine: register port, front, queue and back
// throughput: one byte per cycle unless a closing item waits on out_stall
// a byte's eight shift/xor steps are combinational; a closing item's crc passes the queue, then the result register
// the queue (QUEUE_DEPTH entries) keeps accepting while a finished crc waits on out_stall, until it is full
// reset: arst_n clears the queue, message state and result valid; registers take crc-32 values
// no clearing pass, the block takes input from the first edge after reset
module configurable_crc_engine_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        empty_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] crc_value
);

	cce_pkg::cfg_t   cfg_q;
	cce_pkg::entry_t push_entry;
	cce_pkg::entry_t head_entry;
	logic            queue_full;
	logic            push;
	logic            pop;
	logic            head_valid;
	logic [2:0]      reg_idx;
	logic            wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_mode     <= cce_pkg::WM_32;
			cfg_q.polynomial     <= 32'h04C1_1DB7;
			cfg_q.initial_value  <= 32'hFFFF_FFFF;
			cfg_q.final_xor      <= 32'hFFFF_FFFF;
			cfg_q.reflect_input  <= 1'b1;
			cfg_q.reflect_output <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				cce_pkg::REG_WIDTH_MODE:     cfg_q.width_mode     <= pwdata[1:0];
				cce_pkg::REG_POLYNOMIAL:     cfg_q.polynomial     <= pwdata;
				cce_pkg::REG_INITIAL_VALUE:  cfg_q.initial_value  <= pwdata;
				cce_pkg::REG_FINAL_XOR:      cfg_q.final_xor      <= pwdata;
				cce_pkg::REG_REFLECT_INPUT:  cfg_q.reflect_input  <= pwdata[0];
				cce_pkg::REG_REFLECT_OUTPUT: cfg_q.reflect_output <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cce_pkg::REG_WIDTH_MODE:     prdata = {30'd0, cfg_q.width_mode};
			cce_pkg::REG_POLYNOMIAL:     prdata = cfg_q.polynomial;
			cce_pkg::REG_INITIAL_VALUE:  prdata = cfg_q.initial_value;
			cce_pkg::REG_FINAL_XOR:      prdata = cfg_q.final_xor;
			cce_pkg::REG_REFLECT_INPUT:  prdata = {31'd0, cfg_q.reflect_input};
			cce_pkg::REG_REFLECT_OUTPUT: prdata = {31'd0, cfg_q.reflect_output};
			default:                     prdata = 32'd0;
		endcase
	end

	cce_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.empty_message (empty_message),
		.reflect_input (cfg_q.reflect_input),
		.queue_full    (queue_full),
		.push          (push),
		.entry         (push_entry)
	);

	cce_queue #(
		.WIDTH ($bits(cce_pkg::entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_entry),
		.full      (queue_full),
		.pop       (pop),
		.rdata     (head_entry),
		.not_empty (head_valid)
	);

	cce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.crc_value  (crc_value)
	);

endmodule

/* rtl/cce_checker.sv */
// port-level checks for the crc engine, bound to the top level
module cce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [4:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] crc_value
);

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(crc_value))
		else $error("result changed or dropped while stalled");

	// the queue can only fill up behind a stalled result
	a_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// polynomial register reads back what was written
	a_poly_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == {cce_pkg::REG_POLYNOMIAL, 2'b00}
		|=> (psel && !pwrite && paddr == {cce_pkg::REG_POLYNOMIAL, 2'b00})
		|-> prdata == $past(pwdata))
		else $error("polynomial readback mismatch");

endmodule

bind configurable_crc_engine_unit cce_checker u_cce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.crc_value (crc_value)
);
